[rtl/core/spq_pkg.sv]
// Package for the sorted priority queue: depth, codes, word and control types.
// No dependencies; every other file in rtl/core imports it.
`default_nettype none
package spq_pkg;

	localparam int QUEUE_DEPTH = 8;
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int FILL_W      = 7;

	localparam logic [7:0] EMPTY_MARK = 8'h30;

	typedef enum logic {
		CMD_INSERT = 1'b0,
		CMD_REMOVE = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef struct packed {
		cmd_t       cmd;
		logic [7:0] item_data;
		logic [7:0] item_priority;
	} req_word_t;

	typedef struct packed {
		logic [7:0]        out_data;
		status_t           status;
		logic [FILL_W-1:0] fill_level;
	} rsp_word_t;

	typedef struct packed {
		logic [7:0] data;
		logic [7:0] prio;
	} entry_t;

	// Broadcast from the top level to every cell.
	typedef struct packed {
		logic       ins_en;
		logic       rem_en;
		logic [7:0] new_data;
		logic [7:0] new_prio;
	} cell_ctl_t;

endpackage
`default_nettype wire

[rtl/core/spq_if.sv]
// Valid/ready channel interfaces for the sorted priority queue.
// Depends on spq_pkg for the word types.
`default_nettype none
interface spq_req_if;
	import spq_pkg::*;
	logic      valid;
	logic      ready;
	req_word_t word;
	modport source (output valid, output word, input ready);
	modport sink   (input valid, input word, output ready);
endinterface

interface spq_rsp_if;
	import spq_pkg::*;
	logic      valid;
	logic      ready;
	rsp_word_t word;
	modport source (output valid, output word, input ready);
	modport sink   (input valid, input word, output ready);
endinterface
`default_nettype wire

[rtl/core/sorted_priority_queue.sv]
// Top level of the sorted priority queue: chain of spq_cell, count, output register.
// Depends on spq_pkg, spq_if (spq_req_if, spq_rsp_if) and spq_cell.
//
//  channel | dir | word fields                          | handshake
//  --------+-----+--------------------------------------+-------------
//  req     | in  | cmd, item_data, item_priority        | valid/ready
//  rsp     | out | out_data, status, fill_level         | valid/ready
//
// One word per cycle while rsp.ready is high: a command is applied to the cell
// chain in the cycle it is accepted and its result word sits in the output register
// the next cycle. Throughput is set by the single output register.
// arst_n clears the count and the output valid; cell contents are not reset,
// only slots below the count are ever read. req.ready drops only while a
// result is held and rsp.ready is low.
`default_nettype none
module sorted_priority_queue (
	input  wire logic  clk,
	input  wire logic  arst_n,
	spq_req_if.sink    req,
	spq_rsp_if.source  rsp
);
	import spq_pkg::*;

	logic [CNT_W-1:0] count_q;
	logic             rsp_valid_q;
	rsp_word_t        rsp_word_q;

	logic       accept;
	logic       full;
	logic       empty;
	cell_ctl_t  ctl;
	rsp_word_t  next_word;
	logic [CNT_W-1:0] next_count;

	entry_t              entries [QUEUE_DEPTH];
	logic [QUEUE_DEPTH-1:0] stays;
	logic [QUEUE_DEPTH-1:0] occ;

	// Output register frees itself when the current word leaves.
	assign req.ready = !rsp_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;

	assign full  = (count_q == CNT_W'(QUEUE_DEPTH));
	assign empty = (count_q == '0);

	assign ctl.ins_en   = accept && (req.word.cmd == CMD_INSERT) && !full;
	assign ctl.rem_en   = accept && (req.word.cmd == CMD_REMOVE) && !empty;
	assign ctl.new_data = req.word.item_data;
	assign ctl.new_prio = req.word.item_priority;

	// Cell chain. Head is cell 0; inserts shift toward the tail, removes
	// pull toward the head.
	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		entry_t left_e;
		entry_t right_e;
		logic   left_s;

		assign occ[i] = (CNT_W'(i) < count_q);

		if (i == 0) begin : g_head
			assign left_e = '0;
			assign left_s = 1'b1;
		end else begin : g_mid
			assign left_e = entries[i-1];
			assign left_s = stays[i-1];
		end

		if (i == QUEUE_DEPTH - 1) begin : g_tail
			assign right_e = '0;
		end else begin : g_body
			assign right_e = entries[i+1];
		end

		spq_cell u_cell (
			.clk         (clk),
			.ctl         (ctl),
			.occ         (occ[i]),
			.left_entry  (left_e),
			.left_stay   (left_s),
			.right_entry (right_e),
			.entry       (entries[i]),
			.stay        (stays[i])
		);
	end

	always_comb begin
		next_count = count_q;
		if (ctl.ins_en) begin
			next_count = count_q + CNT_W'(1);
		end else if (ctl.rem_en) begin
			next_count = count_q - CNT_W'(1);
		end
	end

	// Result word for the accepted command.
	always_comb begin
		next_word.out_data   = '0;
		next_word.status     = ST_OK;
		next_word.fill_level = FILL_W'(next_count);
		case (req.word.cmd)
			CMD_INSERT: begin
				if (full) begin
					next_word.status = ST_FULL;
				end
			end
			CMD_REMOVE: begin
				if (empty) begin
					next_word.out_data = EMPTY_MARK;
					next_word.status   = ST_EMPTY;
				end else begin
					next_word.out_data = entries[0].data;
				end
			end
			default: begin
				next_word.status = ST_OK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			count_q <= next_count;
			if (accept) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_word_q <= next_word;
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.word  = rsp_word_q;

endmodule
`default_nettype wire

[rtl/core/spq_cell.sv]
// One slot of the sorted chain: holds an entry, compares, shifts with neighbors.
// Depends on spq_pkg.
`default_nettype none
module spq_cell (
	input  wire logic               clk,
	input  wire spq_pkg::cell_ctl_t ctl,
	input  wire logic               occ,
	input  wire spq_pkg::entry_t    left_entry,
	input  wire logic               left_stay,
	input  wire spq_pkg::entry_t    right_entry,
	output spq_pkg::entry_t         entry,
	output logic                    stay
);
	import spq_pkg::*;

	entry_t entry_q;

	// Entry keeps its slot on insert when it outranks or ties the new item.
	assign stay  = occ && (entry_q.prio >= ctl.new_prio);
	assign entry = entry_q;

	always_ff @(posedge clk) begin
		if (ctl.ins_en && !stay) begin
			if (left_stay) begin
				entry_q.data <= ctl.new_data;
				entry_q.prio <= ctl.new_prio;
			end else begin
				entry_q <= left_entry;
			end
		end else if (ctl.rem_en) begin
			entry_q <= right_entry;
		end
	end

endmodule
`default_nettype wire
